FILE: hdl/sdcf_pkg.sv
// Shared types and constants for the spring-damper contact force block.
`timescale 1ns / 1ps
`default_nettype none
package sdcf_pkg;

    localparam int HEIGHT_W = 24;
    localparam int DEPTH_W  = 25;
    localparam int STAMP_W  = 63;
    localparam int COEF_W   = 20;
    localparam int FORCE_W  = 40;
    localparam int SPRING_W = 44;
    localparam int NUM_W    = 55;
    localparam int VEL_W    = 47;
    localparam int DTERM_W  = 48;
    localparam int CNT_W    = 6;
    localparam int IDX_W    = 2;

    localparam logic [29:0]          NS_PER_S  = 30'd1000000000;
    localparam logic [DTERM_W-1:0]   DAMP_LIM  = 48'h4000_0000_0000;
    localparam logic [FORCE_W-1:0]   FORCE_MAX = 40'hFF_FFFF_FFFF;

    localparam logic signed [HEIGHT_W-1:0] CONTACT_RESET   = -24'sd400000;
    localparam logic [COEF_W-1:0]          STIFFNESS_RESET = 20'd5000;
    localparam logic [COEF_W-1:0]          DAMPING_RESET   = 20'd50;

    localparam logic [IDX_W-1:0] REG_CONTACT   = 2'd0;
    localparam logic [IDX_W-1:0] REG_STIFFNESS = 2'd1;
    localparam logic [IDX_W-1:0] REG_DAMPING   = 2'd2;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);
    localparam logic [CNT_W-1:0] DMUL_TOP  = CNT_W'(COEF_W - 1);

    typedef struct packed {
        logic                contact;
        logic                need_vel;
        logic                vneg;
        logic [HEIGHT_W-1:0] depth;
        logic [DEPTH_W-1:0]  dmag;
        logic [STAMP_W-1:0]  dt;
    } sdcf_entry_t;

    typedef struct packed {
        logic busy;
        logic load;
    } sdcf_back_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DMUL,
        ST_SUM
    } sdcf_state_t;

endpackage
`default_nettype wire

FILE: hdl/sdcf_front.sv
// Front part: takes input items, forms depth and velocity terms, and queues them.
`timescale 1ns / 1ps
`default_nettype none
module sdcf_front
    import sdcf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [HEIGHT_W-1:0] height_um,
    input  wire logic [STAMP_W-1:0]         stamp_ns,
    input  wire logic signed [HEIGHT_W-1:0] contact_height,
    input  wire logic                       q_full,
    output logic                            q_push,
    output sdcf_entry_t                     q_entry
);

    logic signed [DEPTH_W-1:0] last_depth_reg, last_depth_next;
    logic [STAMP_W-1:0]        last_stamp_reg, last_stamp_next;
    logic                      seen_reg, seen_next;

    logic signed [DEPTH_W-1:0] depth;
    logic signed [DEPTH_W:0]   diff;
    logic [STAMP_W-1:0]        dt;
    logic                      later;

    always_comb
    begin
        in_ready = !q_full;
        q_push   = in_valid && !q_full;

        depth = DEPTH_W'(contact_height) - DEPTH_W'(height_um);
        diff  = (DEPTH_W + 1)'(depth) - (DEPTH_W + 1)'(last_depth_reg);
        dt    = stamp_ns - last_stamp_reg;
        later = stamp_ns > last_stamp_reg;

        q_entry.contact  = !depth[DEPTH_W-1] && (depth != '0);
        q_entry.need_vel = seen_reg && later && (dt >= STAMP_W'(2));
        q_entry.vneg     = diff[DEPTH_W];
        q_entry.depth    = depth[HEIGHT_W-1:0];
        q_entry.dmag     = diff[DEPTH_W] ? DEPTH_W'(-diff) : diff[DEPTH_W-1:0];
        q_entry.dt       = dt;

        last_depth_next = last_depth_reg;
        last_stamp_next = last_stamp_reg;
        seen_next       = seen_reg;
        if (q_push)
        begin
            last_depth_next = depth;
            last_stamp_next = stamp_ns;
            seen_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_depth_reg <= '0;
            last_stamp_reg <= '0;
            seen_reg       <= 1'b0;
        end
        else
        begin
            last_depth_reg <= last_depth_next;
            last_stamp_reg <= last_stamp_next;
            seen_reg       <= seen_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/sdcf_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module sdcf_queue
    import sdcf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire sdcf_entry_t wr_entry,
    input  wire logic        pop,
    output sdcf_entry_t      rd_entry,
    output logic             not_empty,
    output logic             full
);

    sdcf_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        not_empty   = count_reg != 2'd0;
        full        = count_reg == 2'd2;
        rd_entry    = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/sdcf_back.sv
// Back part: spring term, radix-2 velocity divider, serial damping multiply, clamp.
`timescale 1ns / 1ps
`default_nettype none
module sdcf_back
    import sdcf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire sdcf_entry_t        q_entry,
    output logic                    q_pop,
    input  wire logic [COEF_W-1:0]  stiffness,
    input  wire logic [COEF_W-1:0]  damping,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [FORCE_W-1:0]      force_un,
    output sdcf_back_stat_t         stat
);

    sdcf_state_t state_reg, state_next;

    logic                 contact_reg, contact_next;
    logic                 need_vel_reg, need_vel_next;
    logic                 vneg_reg, vneg_next;
    logic [HEIGHT_W-1:0]  depth_reg, depth_next;
    logic [DEPTH_W-1:0]   dmag_reg, dmag_next;
    logic [STAMP_W-1:0]   dt_reg, dt_next;
    logic [SPRING_W-1:0]  spring_reg, spring_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [STAMP_W-1:0]   rem_reg, rem_next;
    logic [DTERM_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [FORCE_W-1:0]   force_reg, force_next;

    logic [STAMP_W:0]     rem_shift;
    logic                 ge;
    logic [VEL_W-1:0]     vclamp;
    logic [DTERM_W-1:0]   addend;
    logic [DTERM_W-1:0]   dsum;
    logic [DTERM_W-1:0]   spring_ext;
    logic [DTERM_W-1:0]   total;
    logic                 slot_free;

    always_comb
    begin
        state_next     = state_reg;
        contact_next   = contact_reg;
        need_vel_next  = need_vel_reg;
        vneg_next      = vneg_reg;
        depth_next     = depth_reg;
        dmag_next      = dmag_reg;
        dt_next        = dt_reg;
        spring_next    = spring_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        force_next     = force_reg;
        q_pop          = 1'b0;
        stat.load      = 1'b0;

        // One quotient bit per cycle.
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        ge        = rem_shift >= {1'b0, dt_reg};

        // Velocities at or above the damping limit all give the same saturated term.
        vclamp = (quo_reg[NUM_W-1:VEL_W-1] != '0) ? VEL_W'(DAMP_LIM) : quo_reg[VEL_W-1:0];
        addend = damping[cnt_reg[4:0]] ? DTERM_W'(vclamp) : '0;
        dsum   = {acc_reg[DTERM_W-2:0], 1'b0} + addend;

        spring_ext = DTERM_W'(spring_reg);
        if (vneg_reg)
        begin
            total = (acc_reg >= spring_ext) ? '0 : spring_ext - acc_reg;
        end
        else
        begin
            total = spring_ext + acc_reg;
        end

        slot_free = !out_valid_reg || out_ready;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    contact_next  = q_entry.contact;
                    need_vel_next = q_entry.need_vel;
                    vneg_next     = q_entry.vneg;
                    depth_next    = q_entry.depth;
                    dmag_next     = q_entry.dmag;
                    dt_next       = q_entry.dt;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                spring_next = SPRING_W'(stiffness) * SPRING_W'(depth_reg);
                quo_next    = NUM_W'(dmag_reg) * NUM_W'(NS_PER_S);
                rem_next    = '0;
                acc_next    = '0;
                cnt_next    = '0;
                if (contact_reg && need_vel_reg)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? STAMP_W'(rem_shift - {1'b0, dt_reg}) : rem_shift[STAMP_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = DMUL_TOP;
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL:
            begin
                // Saturation commutes with the doubling, so clamp at every step.
                acc_next = (dsum > DAMP_LIM) ? DAMP_LIM : dsum;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (slot_free)
                begin
                    stat.load      = 1'b1;
                    out_valid_next = 1'b1;
                    if (!contact_reg)
                    begin
                        force_next = '0;
                    end
                    else if (total[DTERM_W-1:FORCE_W] != '0)
                    begin
                        force_next = FORCE_MAX;
                    end
                    else
                    begin
                        force_next = total[FORCE_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        stat.busy = state_reg != ST_IDLE;
        out_valid = out_valid_reg;
        force_un  = force_reg;
    end

    always_ff @(posedge clk)
    begin
        contact_reg  <= contact_next;
        need_vel_reg <= need_vel_next;
        vneg_reg     <= vneg_next;
        depth_reg    <= depth_next;
        dmag_reg     <= dmag_next;
        dt_reg       <= dt_next;
        spring_reg   <= spring_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        force_reg    <= force_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/spring_damper_contact_force_top.sv
// With velocity, an item passes through the 55-step radix-2 divider and the 20-step
// serial damping multiply; without contact or velocity both are skipped. The back part
// takes the next item only when idle, and loads a result once the previous one is taken.
// The two-entry queue lets two further items be taken while the back part is busy.
// Reset clears the configuration registers to their defaults and forgets the previous item.
`timescale 1ns / 1ps
`default_nettype none
module spring_damper_contact_force_top
    import sdcf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [IDX_W-1:0]           cfg_index,
    input  wire logic [HEIGHT_W-1:0]        cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [HEIGHT_W-1:0] height_um,
    input  wire logic [STAMP_W-1:0]         stamp_ns,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [FORCE_W-1:0]              force_un
);

    logic signed [HEIGHT_W-1:0] contact_height_reg, contact_height_next;
    logic [COEF_W-1:0]          stiffness_reg, stiffness_next;
    logic [COEF_W-1:0]          damping_reg, damping_next;

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_not_empty;
    sdcf_entry_t     wr_entry;
    sdcf_entry_t     rd_entry;
    sdcf_back_stat_t back_stat;

    always_comb
    begin
        contact_height_next = contact_height_reg;
        stiffness_next      = stiffness_reg;
        damping_next        = damping_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CONTACT:   contact_height_next = cfg_data;
                REG_STIFFNESS: stiffness_next      = cfg_data[COEF_W-1:0];
                REG_DAMPING:   damping_next        = cfg_data[COEF_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contact_height_reg <= CONTACT_RESET;
            stiffness_reg      <= STIFFNESS_RESET;
            damping_reg        <= DAMPING_RESET;
        end
        else
        begin
            contact_height_reg <= contact_height_next;
            stiffness_reg      <= stiffness_next;
            damping_reg        <= damping_next;
        end
    end

    sdcf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .height_um      (height_um),
        .stamp_ns       (stamp_ns),
        .contact_height (contact_height_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (wr_entry)
    );

    sdcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_entry  (wr_entry),
        .pop       (q_pop),
        .rd_entry  (rd_entry),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    sdcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_entry   (rd_entry),
        .q_pop     (q_pop),
        .stiffness (stiffness_reg),
        .damping   (damping_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .force_un  (force_un),
        .stat      (back_stat)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_not_empty && !back_stat.busy))
        else $error("queue read while empty or back part busy");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.load |-> (!out_valid || out_ready))
        else $error("result loaded over one not yet transferred");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.load |=> (out_valid && !back_stat.busy))
        else $error("loaded result not presented");

endmodule
`default_nettype wire
